// ===== src/mlfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfd_pkg
// Shared types and constants of the length prefixed frame deframer.
// ----------------------------------------------------------------------------
package mlfd_pkg;

  localparam int MAX_ID_BYTES_DEF = 8;
  localparam int ID_LEN_W         = 4;
  localparam int ID_BYTES_W       = 64;
  localparam int LEN_BYTES        = 2;
  localparam int LEN_W            = 16;
  localparam int CFG_IDX_W        = 2;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_BAD_ID  = 2'd2,
    KIND_BAD_LEN = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ID_LENGTH  = 2'd0,
    REG_ID_BYTES   = 2'd1,
    REG_BIG_ENDIAN = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ID_LEN_W-1:0]   id_length;
    logic [ID_BYTES_W-1:0] id_bytes;
    logic                  big_endian;
  } cfg_t;

endpackage

// ===== src/mlfd_byte_if.sv =====
// ----------------------------------------------------------------------------
// mlfd_byte_if
// Input byte channel of the deframer.
// ----------------------------------------------------------------------------
interface mlfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ===== src/mlfd_res_if.sv =====
// ----------------------------------------------------------------------------
// mlfd_res_if
// Result channel of the deframer: payload bytes, empty messages and errors.
// ----------------------------------------------------------------------------
interface mlfd_res_if;
  import mlfd_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       last;

  modport source (output valid, output out_byte, output out_kind, output last, input ready);
  modport sink (input valid, input out_byte, input out_kind, input last, output ready);
endinterface

// ===== src/mlfd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mlfd_cfg_if
// Register write channel of the deframer.
// ----------------------------------------------------------------------------
interface mlfd_cfg_if;
  import mlfd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [ID_BYTES_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/mlfd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mlfd_cfg_regs
// Configuration register file, written through the register channel.
// ----------------------------------------------------------------------------
module mlfd_cfg_regs
  import mlfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mlfd_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_ID_LENGTH:  regs.id_length  <= cfg.data[ID_LEN_W-1:0];
        REG_ID_BYTES:   regs.id_bytes   <= cfg.data;
        REG_BIG_ENDIAN: regs.big_endian <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/mlfd_core.sv =====
// ----------------------------------------------------------------------------
// mlfd_core
// Input register, header/payload tracking and result register.
// ----------------------------------------------------------------------------
module mlfd_core
  import mlfd_pkg::*;
#(
  parameter int MAX_ID_BYTES = MAX_ID_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       regs,
  mlfd_byte_if.sink  stream,
  mlfd_res_if.source result
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALT    = 2'd2
  } phase_t;

  localparam logic [ID_LEN_W-1:0] MaxIdl = ID_LEN_W'(MAX_ID_BYTES);

  phase_t              phase, phase_next;
  logic [ID_LEN_W-1:0] header_index, header_index_next;
  logic [7:0]          length_first_byte, length_first_byte_next;
  logic [LEN_W-1:0]    remaining_count, remaining_count_next;

  logic                in_valid;
  logic [7:0]          in_byte;
  logic                out_valid;
  logic [7:0]          out_byte;
  kind_t               out_kind;
  logic                out_last;

  logic                emit;
  logic [7:0]          res_byte;
  kind_t               res_kind;
  logic                res_last;
  logic [ID_LEN_W-1:0] idl;
  logic [7:0]          want;
  logic [LEN_W-1:0]    total, hdr, rem_dec;
  logic                proceed;

  assign idl     = (regs.id_length > MaxIdl) ? MaxIdl : regs.id_length;
  assign want    = regs.id_bytes[{header_index[2:0], 3'b000} +: 8];
  assign hdr     = LEN_W'(idl) + LEN_W'(LEN_BYTES);
  assign total   = regs.big_endian ? {length_first_byte, in_byte} : {in_byte, length_first_byte};
  assign rem_dec = remaining_count - LEN_W'(1);

  always_comb begin
    phase_next             = phase;
    header_index_next      = header_index;
    length_first_byte_next = length_first_byte;
    remaining_count_next   = remaining_count;
    emit                   = 1'b0;
    res_byte               = '0;
    res_kind               = KIND_PAYLOAD;
    res_last               = 1'b0;
    case (phase)
      PH_PAYLOAD: begin
        remaining_count_next = rem_dec;
        emit                 = 1'b1;
        res_byte             = in_byte;
        if (rem_dec == '0) begin
          phase_next        = PH_HEADER;
          header_index_next = '0;
          res_last          = 1'b1;
        end
      end
      PH_HEADER: begin
        if (header_index < idl) begin
          if (in_byte != want) begin
            phase_next = PH_HALT;
            emit       = 1'b1;
            res_kind   = KIND_BAD_ID;
          end else begin
            header_index_next = header_index + ID_LEN_W'(1);
          end
        end else if (header_index == idl) begin
          length_first_byte_next = in_byte;
          header_index_next      = header_index + ID_LEN_W'(1);
        end else begin
          header_index_next = '0;
          if (total < hdr) begin
            phase_next = PH_HALT;
            emit       = 1'b1;
            res_kind   = KIND_BAD_LEN;
          end else if (total == hdr) begin
            emit     = 1'b1;
            res_kind = KIND_EMPTY;
            res_last = 1'b1;
          end else begin
            remaining_count_next = total - hdr;
            phase_next           = PH_PAYLOAD;
          end
        end
      end
      default: ;
    endcase
  end

  assign proceed      = in_valid && (!emit || !out_valid || result.ready);
  assign stream.ready = !in_valid || proceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid          <= 1'b0;
      out_valid         <= 1'b0;
      phase             <= PH_HEADER;
      header_index      <= '0;
      length_first_byte <= '0;
      remaining_count   <= '0;
    end else begin
      if (stream.valid && stream.ready) begin
        in_valid <= 1'b1;
        in_byte  <= stream.in_byte;
      end else if (proceed) begin
        in_valid <= 1'b0;
      end
      if (proceed) begin
        phase             <= phase_next;
        header_index      <= header_index_next;
        length_first_byte <= length_first_byte_next;
        remaining_count   <= remaining_count_next;
      end
      if (proceed && emit) begin
        out_valid <= 1'b1;
        out_byte  <= res_byte;
        out_kind  <= res_kind;
        out_last  <= res_last;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid    = out_valid;
  assign result.out_byte = out_byte;
  assign result.out_kind = out_kind;
  assign result.last     = out_last;

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HALT) |-> !(proceed && emit))
    else $error("halted deframer produced a result");

  a_bad_id_halts: assert property (@(posedge clk) disable iff (rst)
    (proceed && emit && res_kind == KIND_BAD_ID) |=> (phase == PH_HALT))
    else $error("bad protocol id did not halt");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (remaining_count != '0))
    else $error("payload phase with zero remaining count");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_BAD_ID || out_kind == KIND_BAD_LEN))
      |-> (!out_last && out_byte == '0))
    else $error("error result with last or data set");

endmodule

// ===== src/magic_length_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// magic_length_frame_deframer
// Splits a byte stream into length prefixed frames with a protocol id check.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle with no gaps of its own while the result
// channel takes its results; each byte passes an input register, one step of
// header/payload tracking and a result register. Header bytes give a result
// only for an empty frame or an error: a bad id or a length below the header
// size gives one error result, then all bytes are dropped until reset.
module magic_length_frame_deframer
  import mlfd_pkg::*;
#(
  parameter int MAX_ID_BYTES = MAX_ID_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mlfd_cfg_if.sink   cfg,
  mlfd_byte_if.sink  stream,
  mlfd_res_if.source result
);

  cfg_t regs;

  mlfd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mlfd_core #(
    .MAX_ID_BYTES (MAX_ID_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .stream (stream),
    .result (result)
  );

endmodule
